[design/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and sizes for the session lifecycle timeout tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slt_pkg;

  // Field widths.
  localparam int TIME_W   = 32;
  localparam int BYTE_W   = 48;
  localparam int AMT_W    = 32;
  localparam int MEM_W    = 32;
  localparam int QUEUE_W  = 16;
  localparam int REQ_W    = 4;
  localparam int STATE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Request codes as they arrive on the input channel.
  localparam logic [REQ_W-1:0] REQ_CREATE    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_RX        = 4'd1;
  localparam logic [REQ_W-1:0] REQ_TX        = 4'd2;
  localparam logic [REQ_W-1:0] REQ_MEM       = 4'd3;
  localparam logic [REQ_W-1:0] REQ_ENQUEUE   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_CHECK     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_DRAIN     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_TERMINATE = 4'd8;

  // Session lifecycle states.
  localparam logic [STATE_W-1:0] ST_ACTIVE     = 2'd0;
  localparam logic [STATE_W-1:0] ST_DRAINING   = 2'd1;
  localparam logic [STATE_W-1:0] ST_EXPIRED    = 2'd2;
  localparam logic [STATE_W-1:0] ST_TERMINATED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WARN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd5;

  // Configuration reset values.
  localparam logic [TIME_W-1:0]  IDLE_LIMIT_RST  = TIME_W'(300);
  localparam logic [TIME_W-1:0]  IDLE_WARN_RST   = TIME_W'(240);
  localparam logic [TIME_W-1:0]  ABS_LIMIT_RST   = TIME_W'(86400);
  localparam logic [TIME_W-1:0]  DRAIN_LIMIT_RST = TIME_W'(30);
  localparam logic [MEM_W-1:0]   MEM_LIMIT_RST   = MEM_W'(1048576);
  localparam logic [QUEUE_W-1:0] QUEUE_LIMIT_RST = QUEUE_W'(1024);

  // Operation classes produced by the front.
  typedef enum logic [3:0] {
    OP_CREATE,
    OP_RX,
    OP_TX,
    OP_MEM,
    OP_ENQUEUE,
    OP_DEQUEUE,
    OP_CHECK,
    OP_DRAIN,
    OP_TERMINATE,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_sec;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] session_state;
    logic               transitioned;
    logic               idle_alert;
    logic               memory_exceeded;
    logic               queue_full;
    logic [TIME_W-1:0]  idle_left_sec;
    logic [TIME_W-1:0]  absolute_left_sec;
    logic [QUEUE_W-1:0] queue_depth;
    logic [QUEUE_W-1:0] queue_peak;
    logic [MEM_W-1:0]   memory_peak;
    logic [BYTE_W-1:0]  rx_byte_total;
    logic [BYTE_W-1:0]  tx_byte_total;
  } out_item_t;

  // Classified event as it travels through the queue.
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_sec;
    logic [AMT_W-1:0]  amount;
  } evt_t;

  typedef struct packed {
    logic [TIME_W-1:0]  idle_limit;
    logic [TIME_W-1:0]  idle_warn;
    logic [TIME_W-1:0]  abs_limit;
    logic [TIME_W-1:0]  drain_limit;
    logic [MEM_W-1:0]   mem_limit;
    logic [QUEUE_W-1:0] queue_limit;
  } cfg_t;

  // Queue handshake toward the back.
  typedef struct packed {
    logic valid;
    evt_t evt;
  } fifo_out_t;

endpackage

[design/session_lifecycle_timeout_tracker.sv]
// ----------------------------------------------------------------------------
// session_lifecycle_timeout_tracker: one session's lifecycle and timeouts.
// An event accepted at the input is written into the event queue, then applied
// in the back, which registers its result. Throughput: one event per cycle,
// set by the state update in the back, while the output is not stalled; with
// the output stalled, two more events queue before the input stalls. Reset
// restores the session and configuration defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module session_lifecycle_timeout_tracker import slt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      push;
  evt_t      push_evt;
  logic      fifo_full;
  fifo_out_t head;
  logic      pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit  <= IDLE_LIMIT_RST;
      cfg_q.idle_warn   <= IDLE_WARN_RST;
      cfg_q.abs_limit   <= ABS_LIMIT_RST;
      cfg_q.drain_limit <= DRAIN_LIMIT_RST;
      cfg_q.mem_limit   <= MEM_LIMIT_RST;
      cfg_q.queue_limit <= QUEUE_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IDLE_LIMIT:  cfg_q.idle_limit  <= cfg_data_i[TIME_W-1:0];
        CFG_IDLE_WARN:   cfg_q.idle_warn   <= cfg_data_i[TIME_W-1:0];
        CFG_ABS_LIMIT:   cfg_q.abs_limit   <= cfg_data_i[TIME_W-1:0];
        CFG_DRAIN_LIMIT: cfg_q.drain_limit <= cfg_data_i[TIME_W-1:0];
        CFG_MEM_LIMIT:   cfg_q.mem_limit   <= cfg_data_i[MEM_W-1:0];
        CFG_QUEUE_LIMIT: cfg_q.queue_limit <= cfg_data_i[QUEUE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slt_front u_front (
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .fifo_full_i (fifo_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_evt_o  (push_evt)
  );

  slt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_evt_i (push_evt),
    .pop_i      (pop),
    .full_o     (fifo_full),
    .head_o     (head)
  );

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

[design/slt_front.sv]
// ----------------------------------------------------------------------------
// slt_front
// Accepts input transactions and classifies the request code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_front import slt_pkg::*; (
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     fifo_full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output evt_t     push_evt_o
);

  op_e op;

  always_comb begin
    unique case (in_item_i.req_type)
      REQ_CREATE:    op = OP_CREATE;
      REQ_RX:        op = OP_RX;
      REQ_TX:        op = OP_TX;
      REQ_MEM:       op = OP_MEM;
      REQ_ENQUEUE:   op = OP_ENQUEUE;
      REQ_DEQUEUE:   op = OP_DEQUEUE;
      REQ_CHECK:     op = OP_CHECK;
      REQ_DRAIN:     op = OP_DRAIN;
      REQ_TERMINATE: op = OP_TERMINATE;
      default:       op = OP_NOP;
    endcase
  end

  assign in_stall_o         = fifo_full_i;
  assign push_o             = in_valid_i && !fifo_full_i;
  assign push_evt_o.op      = op;
  assign push_evt_o.now_sec = in_item_i.now_sec;
  assign push_evt_o.amount  = in_item_i.amount;

endmodule

[design/slt_fifo.sv]
// ----------------------------------------------------------------------------
// slt_fifo
// Short queue of classified events between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_fifo import slt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  evt_t      push_evt_i,
  input  logic      pop_i,
  output logic      full_o,
  output fifo_out_t head_o
);

  evt_t             entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_evt_i;
    end
  end

  assign full_o       = (count_q == CNT_W'(FIFO_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.evt   = entry_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("event queue read while empty");
`endif

endmodule

[design/slt_back.sv]
// ----------------------------------------------------------------------------
// slt_back
// Applies one event per unstalled cycle to session state, registering result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_back import slt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  fifo_out_t head_i,
  output logic      pop_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic [STATE_W-1:0] state_q, state_d;
  logic [TIME_W-1:0]  birth_q, birth_d;
  logic [TIME_W-1:0]  act_q, act_d;
  logic [TIME_W-1:0]  drain_q, drain_d;
  logic [BYTE_W-1:0]  rx_q, rx_d;
  logic [BYTE_W-1:0]  tx_q, tx_d;
  logic [QUEUE_W-1:0] qnow_q, qnow_d;
  logic [QUEUE_W-1:0] qpeak_q, qpeak_d;
  logic [MEM_W-1:0]   mpeak_q, mpeak_d;

  logic               out_valid_q;
  out_item_t          out_q, res;

  evt_t               evt;
  logic [BYTE_W-1:0]  amt_ext;
  logic [QUEUE_W-1:0] q_inc;
  logic [TIME_W-1:0]  age_pre, idle_pre, drain_pre;
  logic [TIME_W-1:0]  age_post, idle_post;
  logic               warn, mem_over, q_full;

  assign evt     = head_i.evt;
  assign pop_o   = head_i.valid && (!out_valid_q || !out_stall_i);
  assign amt_ext = BYTE_W'(evt.amount);
  assign q_inc   = (qnow_q != '1) ? qnow_q + QUEUE_W'(1) : qnow_q;

  assign age_pre   = evt.now_sec - birth_q;
  assign idle_pre  = evt.now_sec - act_q;
  assign drain_pre = evt.now_sec - drain_q;

  always_comb begin
    state_d  = state_q;
    birth_d  = birth_q;
    act_d    = act_q;
    drain_d  = drain_q;
    rx_d     = rx_q;
    tx_d     = tx_q;
    qnow_d   = qnow_q;
    qpeak_d  = qpeak_q;
    mpeak_d  = mpeak_q;
    warn     = 1'b0;
    mem_over = 1'b0;
    q_full   = 1'b0;
    unique case (evt.op)
      OP_CREATE: begin
        state_d = ST_ACTIVE;
        birth_d = evt.now_sec;
        act_d   = evt.now_sec;
        drain_d = '0;
        rx_d    = '0;
        tx_d    = '0;
        qnow_d  = '0;
        qpeak_d = '0;
        mpeak_d = '0;
      end
      OP_RX: begin
        rx_d = rx_q + amt_ext;
        if (state_q == ST_ACTIVE) begin
          act_d = evt.now_sec;
        end
      end
      OP_TX: begin
        tx_d = tx_q + amt_ext;
        if (state_q == ST_ACTIVE) begin
          act_d = evt.now_sec;
        end
      end
      OP_MEM: begin
        if (evt.amount > mpeak_q) begin
          mpeak_d = evt.amount;
        end
        mem_over = (evt.amount > cfg_i.mem_limit);
      end
      OP_ENQUEUE: begin
        qnow_d = q_inc;
        if (q_inc > qpeak_q) begin
          qpeak_d = q_inc;
        end
        q_full = (q_inc > cfg_i.queue_limit);
      end
      OP_DEQUEUE: begin
        if (qnow_q != '0) begin
          qnow_d = qnow_q - QUEUE_W'(1);
        end
      end
      OP_CHECK: begin
        // Absolute age wins over drain and idle expiry.
        if (state_q == ST_ACTIVE || state_q == ST_DRAINING) begin
          if (age_pre >= cfg_i.abs_limit) begin
            state_d = ST_EXPIRED;
          end else if (state_q == ST_DRAINING) begin
            if (drain_pre >= cfg_i.drain_limit) begin
              state_d = ST_EXPIRED;
            end
          end else if (idle_pre >= cfg_i.idle_limit) begin
            state_d = ST_EXPIRED;
          end else begin
            warn = (idle_pre >= cfg_i.idle_warn);
          end
        end
      end
      OP_DRAIN: begin
        if (state_q == ST_ACTIVE) begin
          drain_d = evt.now_sec;
          state_d = ST_DRAINING;
        end
      end
      OP_TERMINATE: begin
        state_d = ST_TERMINATED;
      end
      default: begin
      end
    endcase
  end

  // Remaining times are reported against the state after the event.
  assign idle_post = evt.now_sec - act_d;
  assign age_post  = evt.now_sec - birth_d;

  always_comb begin
    res.session_state     = state_d;
    res.transitioned      = (state_d != state_q);
    res.idle_alert        = warn;
    res.memory_exceeded   = mem_over;
    res.queue_full        = q_full;
    res.idle_left_sec     = (state_d == ST_ACTIVE && idle_post < cfg_i.idle_limit) ?
                            cfg_i.idle_limit - idle_post : '0;
    res.absolute_left_sec = (age_post < cfg_i.abs_limit) ? cfg_i.abs_limit - age_post : '0;
    res.queue_depth       = qnow_d;
    res.queue_peak        = qpeak_d;
    res.memory_peak       = mpeak_d;
    res.rx_byte_total     = rx_d;
    res.tx_byte_total     = tx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACTIVE;
      birth_q     <= '0;
      act_q       <= '0;
      drain_q     <= '0;
      rx_q        <= '0;
      tx_q        <= '0;
      qnow_q      <= '0;
      qpeak_q     <= '0;
      mpeak_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q <= state_d;
        birth_q <= birth_d;
        act_q   <= act_d;
        drain_q <= drain_d;
        rx_q    <= rx_d;
        tx_q    <= tx_d;
        qnow_q  <= qnow_d;
        qpeak_q <= qpeak_d;
        mpeak_q <= mpeak_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_create_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && evt.op == OP_CREATE) |=>
      (out_valid_q && out_q.session_state == ST_ACTIVE && out_q.queue_depth == '0))
    else $error("create did not restart the session");
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.queue_peak >= out_q.queue_depth))
    else $error("queue peak below current depth");
  a_terminated_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && state_q == ST_TERMINATED && evt.op != OP_CREATE) |=>
      (state_q == ST_TERMINATED))
    else $error("terminated session left terminated without create");
`endif

endmodule
